### rtl/gdfw_pkg.sv
// Shared types and constants of the depth-first graph walk.
package gdfw_pkg;

    // Fixed field widths
    localparam int VTX_W     = 3;
    localparam int ROW_W     = 8;
    localparam int ROW_COUNT = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [ROW_W-1:0] t_row;
    typedef logic [VTX_W-1:0] t_vtx;

    // Adjacency rows after reset
    localparam t_row ROW_RESET [ROW_COUNT] = '{
        8'd6, 8'd56, 8'd32, 8'd1, 8'd0, 8'd16, 8'd0, 8'd0
    };

    // Walk sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PUSH,
        ST_EMIT
    } t_state;

    // Index of the lowest set bit (zero when none)
    function automatic t_vtx lowest_bit(input t_row bits);
        t_vtx idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = VTX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/gdfw_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module gdfw_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/graph_depth_first_walk.sv
// Depth-first walk over a directed graph of up to VERTEX_COUNT vertices, one adjacency row
// register per vertex, written through the cfg port; the user must write them only while the
// block is idle, which the block itself does not enforce. Each accepted start vertex clears the
// visited marks and yields one output word per reachable vertex in depth-first order, with
// o_last set on the final one; a start vertex at or above VERTEX_COUNT is taken and produces
// nothing. One walk runs at a time, and the input is stalled until its final word sits in the
// output register. The pending stack lives in a RAM with one write port, so neighbours are
// pushed one at a time. There is no clearing pass after reset.
module graph_depth_first_walk #(
    parameter int VERTEX_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Start vertex channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gdfw_pkg::VTX_W-1:0]    i_start_vertex,
    // Visit order channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gdfw_pkg::VTX_W-1:0]    o_vertex,
    output logic                          o_last,
    // Adjacency row writes
    input  logic                          i_cfg_we,
    input  logic [gdfw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gdfw_pkg::ROW_W-1:0]    i_cfg_data
);

    localparam int CNT_W  = $clog2(VERTEX_COUNT + 1);
    localparam int ADDR_W = $clog2(VERTEX_COUNT);
    localparam gdfw_pkg::t_row VMASK = gdfw_pkg::ROW_W'((1 << VERTEX_COUNT) - 1);

    gdfw_pkg::t_state r_state, n_state;
    gdfw_pkg::t_row   r_rows [gdfw_pkg::ROW_COUNT];
    gdfw_pkg::t_row   r_visited, n_visited;
    gdfw_pkg::t_row   r_scan, n_scan;
    gdfw_pkg::t_vtx   r_vert, n_vert;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    gdfw_pkg::t_vtx   r_out_vertex, n_out_vertex;
    logic             r_out_last, n_out_last;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    gdfw_pkg::t_vtx    ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    gdfw_pkg::t_vtx    ram_rdata;

    logic             in_take;
    logic             out_free;
    gdfw_pkg::t_vtx   push_vtx;
    gdfw_pkg::t_row   push_bit;
    gdfw_pkg::t_row   start_bit;
    logic [CNT_W-1:0] count_dec;

    // Pending stack
    gdfw_ram #(
        .WIDTH (gdfw_pkg::VTX_W),
        .DEPTH (VERTEX_COUNT)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != gdfw_pkg::ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign push_vtx    = gdfw_pkg::lowest_bit(r_scan);
    assign push_bit    = gdfw_pkg::ROW_W'(1) << push_vtx;
    assign start_bit   = gdfw_pkg::ROW_W'(1) << i_start_vertex;
    assign count_dec   = r_count - CNT_W'(1);

    // Next state, stack access and output word
    always_comb begin
        n_state      = r_state;
        n_visited    = r_visited;
        n_scan       = r_scan;
        n_vert       = r_vert;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_vertex = r_out_vertex;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_count[ADDR_W-1:0];
        ram_wdata    = push_vtx;
        ram_re       = 1'b0;
        ram_raddr    = count_dec[ADDR_W-1:0];

        case (r_state)
            gdfw_pkg::ST_IDLE: begin
                // Start vertex is pushed and popped at once: expand it directly
                if (in_take && (32'(i_start_vertex) < VERTEX_COUNT)) begin
                    n_vert    = i_start_vertex;
                    n_visited = start_bit;
                    n_scan    = r_rows[i_start_vertex] & ~start_bit & VMASK;
                    n_count   = '0;
                    n_state   = gdfw_pkg::ST_PUSH;
                end
            end
            gdfw_pkg::ST_LOAD: begin
                // Popped vertex arrives from the stack
                n_vert  = ram_rdata;
                n_scan  = r_rows[ram_rdata] & ~r_visited & VMASK;
                n_state = gdfw_pkg::ST_PUSH;
            end
            gdfw_pkg::ST_PUSH: begin
                // One unvisited neighbour per cycle, ascending
                if (r_scan != '0) begin
                    ram_we    = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                    n_visited = r_visited | push_bit;
                    n_scan    = r_scan & (r_scan - gdfw_pkg::ROW_W'(1));
                end else begin
                    n_state = gdfw_pkg::ST_EMIT;
                end
            end
            gdfw_pkg::ST_EMIT: begin
                // Hand the vertex over and pop the next one
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = r_vert;
                    n_out_last   = (r_count == '0);
                    if (r_count == '0) begin
                        n_state = gdfw_pkg::ST_IDLE;
                    end else begin
                        ram_re  = 1'b1;
                        n_count = count_dec;
                        n_state = gdfw_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = gdfw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdfw_pkg::ST_IDLE;
            r_count     <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_vert       <= n_vert;
        r_out_vertex <= n_out_vertex;
        r_out_last   <= n_out_last;
    end

    // Adjacency rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= gdfw_pkg::ROW_RESET;
        end else if (i_cfg_we) begin
            r_rows[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_vertex    = r_out_vertex;
    assign o_last      = r_out_last;

endmodule
